// ----- sv/cct_pkg.sv -----
`timescale 1ns / 1ps

package cct_pkg;

    // Parse modes kept between words
    typedef enum logic [2:0] {
        MODE_START    = 3'd0,
        MODE_QUOTED   = 3'd1,
        MODE_AFTERQ   = 3'd2,
        MODE_UNQUOT   = 3'd3,
        MODE_AFTEREOL = 3'd4
    } mode_t;

    // Result kinds
    typedef enum logic [1:0] {
        KIND_BYTE = 2'd0,
        KIND_CELL = 2'd1,
        KIND_ROW  = 2'd2
    } kind_t;

    // Characters that steer the parser
    localparam logic [7:0] CH_COMMA = 8'h2C;
    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;

    // Token queue between classifier and output stage
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

    // One result word
    typedef struct packed {
        kind_t      kind;
        logic [7:0] data;
        logic       unclosed;
    } result_t;

    // Results caused by one input word (one or two)
    typedef struct packed {
        logic    two;
        result_t first;
        result_t second;
    } entry_t;

endpackage

// ----- sv/cct_front.sv -----
`timescale 1ns / 1ps

module cct_front (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            accept,
    input  logic [7:0]      in_byte,
    input  logic            end_of_input,
    output logic            push,
    output cct_pkg::entry_t entry
);
    import cct_pkg::*;

    mode_t   mode_reg, mode_next;
    logic    is_eol, is_blank;
    logic    start_has;
    result_t start_res;
    mode_t   start_mode;
    result_t cell_end;

    assign is_eol   = (in_byte == CH_LF) || (in_byte == CH_CR);
    assign is_blank = (in_byte == CH_SPACE) || (in_byte == CH_TAB);

    // Word handled as at cell start
    always_comb begin
        start_has  = 1'b1;
        start_res  = '{kind: KIND_ROW, data: 8'd0, unclosed: 1'b0};
        start_mode = MODE_START;
        if (end_of_input) begin
            start_mode = MODE_START;
        end else if (is_blank) begin
            start_has = 1'b0;
        end else if (is_eol) begin
            start_mode = MODE_AFTEREOL;
        end else if (in_byte == CH_COMMA) begin
            start_res.kind = KIND_CELL;
        end else if (in_byte == CH_QUOTE) begin
            start_has  = 1'b0;
            start_mode = MODE_QUOTED;
        end else begin
            start_res.kind = KIND_BYTE;
            start_res.data = in_byte;
            start_mode     = MODE_UNQUOT;
        end
    end

    assign cell_end = '{kind: KIND_CELL, data: 8'd0, unclosed: 1'b0};

    // Mode transitions and token build
    always_comb begin
        mode_next    = mode_reg;
        push         = 1'b0;
        entry.two    = 1'b0;
        entry.first  = start_res;
        entry.second = '{kind: KIND_ROW, data: 8'd0, unclosed: 1'b0};
        unique case (mode_reg)
            MODE_QUOTED: begin
                if (end_of_input) begin
                    push                 = 1'b1;
                    entry.two            = 1'b1;
                    entry.first          = cell_end;
                    entry.first.unclosed = 1'b1;
                    mode_next            = MODE_START;
                end else if (in_byte == CH_QUOTE) begin
                    mode_next = MODE_AFTERQ;
                end else begin
                    push        = 1'b1;
                    entry.first = '{kind: KIND_BYTE, data: in_byte, unclosed: 1'b0};
                end
            end
            MODE_AFTERQ: begin
                push        = 1'b1;
                entry.first = cell_end;
                if (!end_of_input && in_byte == CH_COMMA) begin
                    mode_next = MODE_START;
                end else begin
                    entry.two    = start_has;
                    entry.second = start_res;
                    mode_next    = start_mode;
                end
            end
            MODE_UNQUOT: begin
                if (end_of_input) begin
                    push        = 1'b1;
                    entry.two   = 1'b1;
                    entry.first = cell_end;
                    mode_next   = MODE_START;
                end else if (in_byte == CH_COMMA) begin
                    push        = 1'b1;
                    entry.first = cell_end;
                    mode_next   = MODE_START;
                end else if (is_eol) begin
                    push        = 1'b1;
                    entry.two   = 1'b1;
                    entry.first = cell_end;
                    mode_next   = MODE_AFTEREOL;
                end else begin
                    push        = 1'b1;
                    entry.first = '{kind: KIND_BYTE, data: in_byte, unclosed: 1'b0};
                end
            end
            MODE_AFTEREOL: begin
                if (!end_of_input && is_eol) begin
                    mode_next = MODE_START;
                end else begin
                    push      = start_has;
                    mode_next = start_mode;
                end
            end
            default: begin
                push      = start_has;
                mode_next = start_mode;
            end
        endcase
        push = push & accept;
    end

    // Mode register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg <= MODE_START;
        end else if (accept) begin
            mode_reg <= mode_next;
        end
    end

endmodule

// ----- sv/cct_queue.sv -----
`timescale 1ns / 1ps

module cct_queue (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            push,
    input  cct_pkg::entry_t push_entry,
    input  logic            pop,
    output cct_pkg::entry_t head,
    output logic            empty,
    output logic            full
);
    import cct_pkg::*;

    entry_t                slot_reg [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [QUEUE_CW-1:0]   count_reg, count_next;

    assign empty = (count_reg == '0);
    assign full  = (count_reg == QUEUE_CW'(QUEUE_DEPTH));
    assign head  = slot_reg[rd_ptr_reg];

    always_comb begin
        count_next = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (!push && pop) begin
            count_next = count_reg - 1'b1;
        end
    end

    // Pointers and fill count
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            count_reg <= count_next;
        end
    end

    // Storage
    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= push_entry;
        end
    end

    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        push |-> (!full || pop))
        else $error("token queue overflow");

    a_no_underflow: assert property (@(posedge aclk) disable iff (!aresetn)
        pop |-> !empty)
        else $error("token queue underflow");

    a_ptr_count: assert property (@(posedge aclk) disable iff (!aresetn)
        (count_reg <= QUEUE_CW'(QUEUE_DEPTH)) &&
        (QUEUE_AW'(wr_ptr_reg - rd_ptr_reg) == QUEUE_AW'(count_reg)))
        else $error("token queue pointers disagree with count");

endmodule

// ----- sv/cct_back.sv -----
`timescale 1ns / 1ps

module cct_back (
    input  logic            aclk,
    input  logic            aresetn,
    input  cct_pkg::entry_t head,
    input  logic            empty,
    output logic            pop,
    output logic            m_tvalid,
    input  logic            m_tready,
    output logic [7:0]      m_tdata,
    output logic [2:0]      m_tuser,
    output logic            m_tlast
);
    import cct_pkg::*;

    logic    sub_reg, sub_next;
    logic    valid_reg, valid_next;
    result_t res_reg, res_sel;
    logic    last_reg, last_sel;
    logic    load;

    // Pick the next result word of the head token
    assign load     = !empty && (!valid_reg || m_tready);
    assign res_sel  = sub_reg ? head.second : head.first;
    assign last_sel = !head.two || sub_reg;
    assign pop      = load && last_sel;

    always_comb begin
        sub_next   = sub_reg;
        valid_next = valid_reg;
        if (load) begin
            sub_next   = !last_sel;
            valid_next = 1'b1;
        end else if (m_tready) begin
            valid_next = 1'b0;
        end
    end

    // Control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sub_reg   <= 1'b0;
            valid_reg <= 1'b0;
        end else begin
            sub_reg   <= sub_next;
            valid_reg <= valid_next;
        end
    end

    // Output payload
    always_ff @(posedge aclk) begin
        if (load) begin
            res_reg  <= res_sel;
            last_reg <= last_sel;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = res_reg.data;
    assign m_tuser  = {res_reg.unclosed, res_reg.kind};
    assign m_tlast  = last_reg;

    a_second_half: assert property (@(posedge aclk) disable iff (!aresetn)
        sub_reg |-> (!empty && head.two))
        else $error("second result pending without a two-result token");

    a_unclosed_on_cell: assert property (@(posedge aclk) disable iff (!aresetn)
        (valid_reg && res_reg.unclosed) |-> (res_reg.kind == KIND_CELL))
        else $error("unclosed flag on a word that is not a cell end");

    a_first_not_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (load && !last_sel) |=> (sub_reg && valid_reg && !last_reg))
        else $error("first of two results marked last");

endmodule

// ----- sv/csv_cell_tokenizer_core.sv -----
// Path: an accepted byte's results are written into the token queue and then
// loaded into the output register that drives m_*.
// Throughput: one input word per cycle; a byte that yields two results
// sends them as two output words, and the four-entry token queue absorbs these.
// Input stalls only when the token queue is full.
// Reset: aresetn synchronous, active low; parser returns to cell start and
// the token queue and output register are emptied.
`timescale 1ns / 1ps

module csv_cell_tokenizer_core (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] in_byte
    input  logic       s_tuser,   // [0] end_of_input
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,   // [7:0] data_byte
    output logic [2:0] m_tuser,   // [1:0] kind, [2] quote_unclosed
    output logic       m_tlast
);
    import cct_pkg::*;

    logic   accept;
    logic   push, pop, empty, full;
    entry_t push_entry, head;

    assign s_tready = !full;
    assign accept   = s_tvalid && s_tready;

    // Classifier and parse mode
    cct_front u_front (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .accept       (accept),
        .in_byte      (s_tdata),
        .end_of_input (s_tuser),
        .push         (push),
        .entry        (push_entry)
    );

    // Token queue
    cct_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (push),
        .push_entry (push_entry),
        .pop        (pop),
        .head       (head),
        .empty      (empty),
        .full       (full)
    );

    // Result serializer and output register
    cct_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .head     (head),
        .empty    (empty),
        .pop      (pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

endmodule

// ----- tb/tb_csv_cell_tokenizer_core.sv -----
`timescale 1ns / 1ps

module tb_csv_cell_tokenizer_core;
    import cct_pkg::*;

    // One input word: a CSV byte or an end-of-input mark
    typedef struct packed {
        logic [7:0] ch;
        logic       eoi;
    } in_word_t;

    // One predicted result word
    typedef struct packed {
        kind_t      kind;
        logic [7:0] data;
        logic       unclosed;
        logic       last;
    } token_t;

    logic       aclk = 1'b0;
    logic       aresetn = 1'b0;
    logic       s_tvalid = 1'b0;
    logic       s_tready;
    logic [7:0] s_tdata = 8'h00;   // [7:0] in_byte
    logic       s_tuser = 1'b0;    // [0] end_of_input
    logic       m_tvalid;
    logic       m_tready = 1'b0;
    logic [7:0] m_tdata;           // [7:0] data_byte
    logic [2:0] m_tuser;           // [1:0] kind, [2] quote_unclosed
    logic       m_tlast;

    in_word_t pending_words[$];
    token_t   tokens_due[$];
    token_t   batch[$];
    mode_t    mode_now = MODE_START;

    int   send_idle_pct = 0;
    int   recv_stall_pct = 0;
    logic recv_hold = 1'b0;
    logic hold_go = 1'b0;
    logic in_took = 1'b0;
    int   n_queued = 0;
    int   errors = 0;

    csv_cell_tokenizer_core uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    initial begin
        forever #1 aclk = ~aclk;
    end

    // Run limit
    initial begin
        #2000000;
        $display("FAILURE");
        $finish;
    end

    // ---------------------------------------------------------------
    // Parser prediction
    // ---------------------------------------------------------------
    function automatic logic is_break(logic [7:0] c);
        return (c == CH_CR) || (c == CH_LF);
    endfunction

    function automatic token_t tok(kind_t k, logic [7:0] d, logic u);
        token_t t;
        t.kind = k;
        t.data = d;
        t.unclosed = u;
        t.last = 1'b0;
        return t;
    endfunction

    // Rules that apply at the start of a cell
    task automatic start_rules(input logic [7:0] c, input logic eoi);
        if (eoi) begin
            mode_now = MODE_START;
            batch.push_back(tok(KIND_ROW, 8'h00, 1'b0));
        end else if (c == CH_SPACE || c == CH_TAB) begin
            mode_now = MODE_START;
        end else if (is_break(c)) begin
            mode_now = MODE_AFTEREOL;
            batch.push_back(tok(KIND_ROW, 8'h00, 1'b0));
        end else if (c == CH_COMMA) begin
            mode_now = MODE_START;
            batch.push_back(tok(KIND_CELL, 8'h00, 1'b0));
        end else if (c == CH_QUOTE) begin
            mode_now = MODE_QUOTED;
        end else begin
            mode_now = MODE_UNQUOT;
            batch.push_back(tok(KIND_BYTE, c, 1'b0));
        end
    endtask

    // Advance the parse mode by one word and queue the tokens it yields
    task automatic parse_word(input logic [7:0] c, input logic eoi);
        batch.delete();
        case (mode_now)
            MODE_QUOTED: begin
                if (eoi) begin
                    batch.push_back(tok(KIND_CELL, 8'h00, 1'b1));
                    batch.push_back(tok(KIND_ROW, 8'h00, 1'b0));
                    mode_now = MODE_START;
                end else if (c == CH_QUOTE) begin
                    mode_now = MODE_AFTERQ;
                end else begin
                    batch.push_back(tok(KIND_BYTE, c, 1'b0));
                end
            end
            MODE_AFTERQ: begin
                batch.push_back(tok(KIND_CELL, 8'h00, 1'b0));
                if (!eoi && c == CH_COMMA)
                    mode_now = MODE_START;
                else
                    start_rules(c, eoi);
            end
            MODE_UNQUOT: begin
                if (eoi) begin
                    batch.push_back(tok(KIND_CELL, 8'h00, 1'b0));
                    batch.push_back(tok(KIND_ROW, 8'h00, 1'b0));
                    mode_now = MODE_START;
                end else if (c == CH_COMMA) begin
                    batch.push_back(tok(KIND_CELL, 8'h00, 1'b0));
                    mode_now = MODE_START;
                end else if (is_break(c)) begin
                    batch.push_back(tok(KIND_CELL, 8'h00, 1'b0));
                    batch.push_back(tok(KIND_ROW, 8'h00, 1'b0));
                    mode_now = MODE_AFTEREOL;
                end else begin
                    batch.push_back(tok(KIND_BYTE, c, 1'b0));
                end
            end
            MODE_AFTEREOL: begin
                // second half of a CR/LF pair is swallowed
                if (!eoi && is_break(c))
                    mode_now = MODE_START;
                else
                    start_rules(c, eoi);
            end
            default: start_rules(c, eoi);
        endcase
        if (batch.size() > 0)
            batch[batch.size() - 1].last = 1'b1;
        foreach (batch[i])
            tokens_due.push_back(batch[i]);
    endtask

    // ---------------------------------------------------------------
    // Driver: input word and output ready change on the falling edge
    // ---------------------------------------------------------------
    always @(negedge aclk) begin
        in_word_t w;
        if (!s_tvalid || in_took) begin
            if (pending_words.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                w = pending_words.pop_front();
                s_tvalid <= 1'b1;
                s_tdata <= w.ch;
                s_tuser <= w.eoi;
            end else begin
                s_tvalid <= 1'b0;
            end
        end
        m_tready <= !recv_hold && ($urandom_range(99) >= recv_stall_pct);
    end

    // Long receiver hold-off, counted in its own process
    initial begin
        wait (hold_go);
        recv_hold = 1'b1;
        repeat (300) @(posedge aclk);
        recv_hold = 1'b0;
    end

    // ---------------------------------------------------------------
    // Monitor: accepted input words predict, accepted results check
    // ---------------------------------------------------------------
    always @(posedge aclk) begin
        token_t want;
        in_took = aresetn && s_tvalid && s_tready;
        if (in_took)
            parse_word(s_tdata, s_tuser);
        if (aresetn && m_tvalid && m_tready) begin
            if (tokens_due.size() == 0) begin
                $error("unexpected result word: kind %0d data %0h", m_tuser[1:0], m_tdata);
                errors++;
            end else begin
                want = tokens_due.pop_front();
                if (m_tuser[1:0] !== want.kind) begin
                    $error("kind: exp %0d act %0d", want.kind, m_tuser[1:0]);
                    errors++;
                end
                if (m_tdata !== want.data) begin
                    $error("data_byte: exp %0h act %0h", want.data, m_tdata);
                    errors++;
                end
                if (m_tuser[2] !== want.unclosed) begin
                    $error("quote_unclosed: exp %0b act %0b", want.unclosed, m_tuser[2]);
                    errors++;
                end
                if (m_tlast !== want.last) begin
                    $error("last: exp %0b act %0b", want.last, m_tlast);
                    errors++;
                end
            end
        end
    end

    // ---------------------------------------------------------------
    // Stimulus helpers
    // ---------------------------------------------------------------
    task automatic push_ch(input logic [7:0] c);
        pending_words.push_back('{ch: c, eoi: 1'b0});
        n_queued++;
    endtask

    // in_byte is don't-care on end of input, so it carries random bits
    task automatic push_eoi();
        pending_words.push_back('{ch: 8'($urandom_range(255)), eoi: 1'b1});
        n_queued++;
    endtask

    function automatic logic [7:0] plain_char();
        logic [7:0] c;
        do c = 8'($urandom_range(255));
        while (c == CH_COMMA || c == CH_QUOTE || is_break(c));
        return c;
    endfunction

    function automatic logic [7:0] quoted_char();
        logic [7:0] c;
        case ($urandom_range(7))
            0: c = CH_COMMA;
            1: c = CH_CR;
            2: c = CH_LF;
            default: do c = 8'($urandom_range(255)); while (c == CH_QUOTE);
        endcase
        return c;
    endfunction

    task automatic gen_cell();
        int n;
        repeat ($urandom_range(2))
            push_ch($urandom_range(1) ? CH_SPACE : CH_TAB);
        case ($urandom_range(5))
            0: ;  // empty cell
            1, 2: begin
                push_ch(CH_QUOTE);
                n = $urandom_range(6);
                repeat (n) push_ch(quoted_char());
                push_ch(CH_QUOTE);
                if ($urandom_range(7) == 0)
                    push_ch(CH_SPACE);
            end
            default: begin
                n = $urandom_range(1, 6);
                repeat (n) push_ch(plain_char());
            end
        endcase
    endtask

    // A row of cells with one of the line-break forms, or end of input
    task automatic gen_row();
        int n;
        n = $urandom_range(1, 4);
        for (int i = 0; i < n; i++) begin
            if (i > 0)
                push_ch(CH_COMMA);
            gen_cell();
        end
        if ($urandom_range(7) == 0)
            push_ch(CH_COMMA);
        case ($urandom_range(11))
            0: push_eoi();
            1: begin
                // end of input inside an open quote
                push_ch(CH_QUOTE);
                repeat ($urandom_range(3)) push_ch(quoted_char());
                push_eoi();
            end
            2, 3, 4: push_ch(CH_LF);
            5, 6: push_ch(CH_CR);
            7, 8: begin
                push_ch(CH_CR);
                push_ch(CH_LF);
            end
            9: begin
                push_ch(CH_LF);
                push_ch(CH_CR);
            end
            default: begin
                push_ch(CH_CR);
                push_ch(CH_CR);
            end
        endcase
    endtask

    task automatic gen_noise();
        repeat ($urandom_range(1, 8)) begin
            if ($urandom_range(15) == 0)
                push_eoi();
            else
                push_ch(8'($urandom_range(255)));
        end
    endtask

    task automatic drain();
        while (pending_words.size() != 0 || s_tvalid || tokens_due.size() != 0)
            @(posedge aclk);
    endtask

    task automatic run_phase(input int n_words, input int sidle, input int rstall);
        send_idle_pct = sidle;
        recv_stall_pct = rstall;
        n_queued = 0;
        while (n_queued < n_words) begin
            if ($urandom_range(9) < 8)
                gen_row();
            else
                gen_noise();
        end
        drain();
    endtask

    // ---------------------------------------------------------------
    // Test sequence
    // ---------------------------------------------------------------
    initial begin
        repeat (7) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // Directed: every parse mode and a selection of its transitions
        push_ch(CH_SPACE);       // skipped at cell start
        push_ch(CH_TAB);
        push_ch("a");            // unquoted content
        push_ch(CH_COMMA);       // cell end
        push_ch(CH_QUOTE);       // open quote
        push_ch(CH_COMMA);       // comma inside quotes is content
        push_ch(CH_CR);          // so is a line break
        push_ch(8'hFF);
        push_ch(CH_QUOTE);       // close quote
        push_ch(CH_COMMA);       // cell end after closing quote
        push_ch(CH_QUOTE);
        push_ch(CH_QUOTE);       // empty quoted cell
        push_ch(CH_CR);          // cell end, then row end
        push_ch(CH_LF);          // folded into the same row end
        push_ch(CH_COMMA);       // empty cell
        push_ch(CH_LF);          // trailing comma: row end only
        push_ch(8'h00);          // content right after a line break
        push_eoi();              // end of input in an unquoted cell
        push_eoi();              // end of input at cell start
        push_ch(CH_QUOTE);
        push_ch(8'h00);
        push_eoi();              // end of input with quote open
        push_ch(CH_QUOTE);
        push_ch(CH_QUOTE);
        push_eoi();              // end of input after closing quote
        push_ch(CH_LF);
        push_eoi();              // end of input just after a line break
        drain();

        run_phase(200, 0, 0);
        run_phase(180, 78, 0);
        run_phase(180, 0, 78);
        run_phase(180, 17, 17);

        // Receiver held off while words keep coming: input must stall
        send_idle_pct = 0;
        recv_stall_pct = 0;
        hold_go = 1'b1;
        run_phase(60, 0, 0);

        run_phase(100, 17, 78);

        repeat (20) @(posedge aclk);
        if (errors == 0 && tokens_due.size() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
